/* rtl/text_console_cursor_scroll_top_assert.svh */
// Assertion macros for the console engine.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define TCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console engine assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console engine assertion failed");

`else

`define TCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/tcc_pkg.sv */
package tcc_pkg;

    // command codes
    localparam logic [2:0] MODE_WRITE   = 3'd0;
    localparam logic [2:0] MODE_NEWLINE = 3'd1;
    localparam logic [2:0] MODE_CLEAR   = 3'd2;
    localparam logic [2:0] MODE_SETCUR  = 3'd3;
    localparam logic [2:0] MODE_PUT     = 3'd4;
    localparam logic [2:0] MODE_COLOR   = 3'd5;
    localparam logic [2:0] MODE_READ    = 3'd6;

    // configuration register indexes
    localparam int          CFG_IDX_W      = 1;
    localparam logic [0:0]  CFG_FILL_CHAR  = 1'b0;
    localparam logic [0:0]  CFG_FILL_COLOR = 1'b1;

    localparam logic [7:0]  FILL_CHAR_RST  = 8'd32;
    localparam logic [7:0]  FILL_COLOR_RST = 8'd0;

    localparam int          QUEUE_DEPTH    = 2;

    // classified command, coordinates already clamped
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] char_code;
        logic [5:0] column;
        logic [4:0] line;
        logic [7:0] line_color;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_char;
        logic [5:0] cursor_column;
        logic [4:0] cursor_line;
        logic       did_scroll;
    } t_res;

endpackage

/* rtl/tcc_fifo.sv */
module tcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW:0]      r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* rtl/tcc_front.sv */
module tcc_front
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int LINES   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [5:0] i_column,
    input  logic [4:0] i_line,
    input  logic [7:0] i_line_color,
    output logic       o_full,
    input  logic       i_cmd_pop,
    output t_cmd       o_cmd,
    output logic       o_cmd_empty
);

    t_cmd                  cmd_in;
    logic [$bits(t_cmd)-1:0] q_data;

    // clamp coordinates to the screen
    always_comb begin
        cmd_in.mode       = i_mode;
        cmd_in.char_code  = i_char_code;
        cmd_in.column     = (int'(i_column) >= COLUMNS) ? 6'(COLUMNS-1) : i_column;
        cmd_in.line       = (int'(i_line) >= LINES) ? 5'(LINES-1) : i_line;
        cmd_in.line_color = i_line_color;
    end

    tcc_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_data),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = q_data;

endmodule

/* rtl/tcc_back.sv */
module tcc_back
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int LINES   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  t_cmd                 i_cmd,
    input  logic                 i_cmd_empty,
    output logic                 o_cmd_pop,
    input  logic                 i_res_full,
    output logic                 o_res_push,
    output t_res                 o_res,
    output logic                 o_busy
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int LW    = $clog2(LINES);
    localparam int SW    = LW + 1;
    localparam int AW    = LW + CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_FILL  = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [LW-1:0] r_line, n_line;
    logic [LW-1:0] r_base, n_base;
    logic [LW-1:0] r_row, n_row;
    logic [CW-1:0] r_ccol, n_ccol;
    logic [7:0]    r_fill_char;
    logic [7:0]    r_fill_color;

    logic [7:0]    r_chars [DEPTH];
    logic [7:0]    r_colors [LINES];
    logic [7:0]    r_rdata;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          clr_we;
    logic [LW-1:0] clr_waddr;
    logic [7:0]    clr_wdata;
    logic          wrap;
    logic [LW-1:0] cmd_line;
    logic [CW-1:0] cmd_col;

    // map a screen line to its store row through the scroll offset
    function automatic logic [LW-1:0] phys_row(input logic [LW-1:0] l,
                                               input logic [LW-1:0] b);
        logic [SW-1:0] s;
        s = {1'b0, l} + {1'b0, b};
        if (s >= SW'(LINES)) begin
            s = s - SW'(LINES);
        end
        return s[LW-1:0];
    endfunction

    assign cmd_line  = LW'(i_cmd.line);
    assign cmd_col   = CW'(i_cmd.column);
    assign mem_raddr = {phys_row(cmd_line, r_base), cmd_col};
    assign o_busy    = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_line     = r_line;
        n_base     = r_base;
        n_row      = r_row;
        n_ccol     = r_ccol;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = {r_row, r_ccol};
        mem_wdata  = r_fill_char;
        clr_we     = 1'b0;
        clr_waddr  = r_row;
        clr_wdata  = r_fill_color;
        wrap       = 1'b0;
        o_res.read_char     = 8'd0;
        o_res.did_scroll    = 1'b0;
        o_res.cursor_column = 6'(r_col);
        o_res.cursor_line   = 5'(r_line);

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop  = 1'b1;
                    o_res_push = 1'b1;
                    unique case (i_cmd.mode)
                        MODE_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = {phys_row(r_line, r_base), r_col};
                            mem_wdata = i_cmd.char_code;
                            if (r_col == CW'(COLUMNS-1)) begin
                                wrap = 1'b1;
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                        end
                        MODE_NEWLINE: begin
                            wrap = 1'b1;
                        end
                        MODE_CLEAR: begin
                            o_res_push = 1'b0;
                            n_col   = '0;
                            n_line  = '0;
                            n_base  = '0;
                            n_row   = '0;
                            n_ccol  = '0;
                            n_state = S_CLEAR;
                        end
                        MODE_SETCUR: begin
                            n_col  = cmd_col;
                            n_line = cmd_line;
                        end
                        MODE_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = mem_raddr;
                            mem_wdata = i_cmd.char_code;
                        end
                        MODE_COLOR: begin
                            clr_we    = 1'b1;
                            clr_waddr = phys_row(cmd_line, r_base);
                            clr_wdata = i_cmd.line_color;
                        end
                        MODE_READ: begin
                            o_res_push = 1'b0;
                            n_state    = S_READ;
                        end
                        default: begin
                        end
                    endcase
                    if (wrap) begin
                        n_col = '0;
                        if (r_line == LW'(LINES-1)) begin
                            // scroll: the old top row becomes the new bottom line
                            o_res_push = 1'b0;
                            n_base  = (r_base == LW'(LINES-1)) ? '0 : r_base + LW'(1);
                            n_row   = r_base;
                            n_ccol  = '0;
                            clr_we    = 1'b1;
                            clr_waddr = r_base;
                            clr_wdata = r_fill_color;
                            n_state = S_FILL;
                        end else begin
                            n_line = r_line + LW'(1);
                        end
                    end
                    o_res.cursor_column = 6'(n_col);
                    o_res.cursor_line   = 5'(n_line);
                end
            end
            S_READ: begin
                o_res_push      = 1'b1;
                o_res.read_char = r_rdata;
                n_state         = S_IDLE;
            end
            S_FILL: begin
                mem_we = 1'b1;
                if (r_ccol == CW'(COLUMNS-1)) begin
                    o_res_push       = 1'b1;
                    o_res.did_scroll = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_ccol = r_ccol + CW'(1);
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                clr_we = (r_ccol == '0);
                if (r_ccol == CW'(COLUMNS-1)) begin
                    n_ccol = '0;
                    if (r_row == LW'(LINES-1)) begin
                        o_res_push = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_row = r_row + LW'(1);
                    end
                end else begin
                    n_ccol = r_ccol + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_line       <= '0;
            r_base       <= '0;
            r_row        <= '0;
            r_ccol       <= '0;
            r_fill_char  <= FILL_CHAR_RST;
            r_fill_color <= FILL_COLOR_RST;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_line  <= n_line;
            r_base  <= n_base;
            r_row   <= n_row;
            r_ccol  <= n_ccol;
            if (i_cfg_we && i_cfg_idx == CFG_FILL_CHAR) begin
                r_fill_char <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_FILL_COLOR) begin
                r_fill_color <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_chars[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_chars[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (clr_we) begin
            r_colors[clr_waddr] <= clr_wdata;
        end
    end

endmodule

/* rtl/text_console_cursor_scroll_top.sv */
// An accepted item passes the command queue, the execute stage and the result queue; a read also passes S_READ.
// Throughput: one item per cycle in the execute stage while the result queue has room; a read
// adds S_READ, a scrolling write or new line a bottom-row refill sweep, clear a full store sweep.
// Reset (synchronous, active low): cursor and scroll offset to zero, both queues empty,
// fill_char 32, fill_color 0; character store and line colors keep no reset value.
module text_console_cursor_scroll_top
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int LINES   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command side
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           i_mode,
    input  logic [7:0]           i_char_code,
    input  logic [5:0]           i_column,
    input  logic [4:0]           i_line,
    input  logic [7:0]           i_line_color,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           o_read_char,
    output logic [5:0]           o_cursor_column,
    output logic [4:0]           o_cursor_line,
    output logic                 o_did_scroll,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);

`include "text_console_cursor_scroll_top_assert.svh"

    // Front: clamp coordinates and queue the item. The queue lets the
    // front keep accepting, until it is full, while the back end sweeps the store.
    t_cmd                    cmd;
    logic                    cmd_empty;
    logic                    cmd_pop;

    // Back: cursor, scroll offset, character store and line colors.
    // Scrolling never moves data; it advances a row offset and refills
    // the row that wraps around to the bottom.
    t_res                    res;
    logic                    res_push;
    logic                    res_full;
    logic                    busy;
    logic [$bits(t_res)-1:0] res_q;
    t_res                    res_out;

    tcc_front #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_column     (i_column),
        .i_line       (i_line),
        .i_line_color (i_line_color),
        .o_full       (full),
        .i_cmd_pop    (cmd_pop),
        .o_cmd        (cmd),
        .o_cmd_empty  (cmd_empty)
    );

    tcc_back #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res),
        .o_busy      (busy)
    );

    // Result queue: holds finished items while the consumer stalls, so the
    // back end keeps executing until the queue is full.
    tcc_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign res_out         = res_q;
    assign o_read_char     = res_out.read_char;
    assign o_cursor_column = res_out.cursor_column;
    assign o_cursor_line   = res_out.cursor_line;
    assign o_did_scroll    = res_out.did_scroll;

    // The back end only starts an item when the result queue has room.
    `TCC_ASSERT_IMP(a_res_room, i_clk, i_rst_n, res_push, !res_full)
    // Never take a new item in the middle of a sweep or a read.
    `TCC_ASSERT_IMP(a_busy_no_pop, i_clk, i_rst_n, busy, !cmd_pop)
    // Every item taken from the command queue was really there.
    `TCC_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, cmd_pop, !cmd_empty)
    // A sweep always ends in a result: after a push the back end is free.
    `TCC_ASSERT_NXT(a_push_frees, i_clk, i_rst_n, res_push, !busy)

endmodule

/* tb/text_console_cursor_scroll_checker.sv */
module text_console_cursor_scroll_checker
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int LINES   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [2:0]           i_mode,
    input  logic [7:0]           i_char_code,
    input  logic [5:0]           i_column,
    input  logic [4:0]           i_line,
    input  logic [7:0]           i_line_color,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic [7:0]           i_read_char,
    input  logic [5:0]           i_cursor_column,
    input  logic [4:0]           i_cursor_line,
    input  logic                 i_did_scroll,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  screen [LINES*COLUMNS];
    logic [7:0]  row_color [LINES];
    int unsigned cur_col;
    int unsigned cur_line;
    logic [7:0]  fill_char;
    logic [7:0]  fill_color;
    t_res        cursor_reports [$];
    int          fail_count = 0;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned count);
        return (v >= count) ? count - 1 : v;
    endfunction

    // shift every row up one, refill the bottom row
    task automatic scroll_screen();
        for (int i = 0; i < (LINES - 1) * COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
        for (int x = 0; x < COLUMNS; x++)
            screen[(LINES - 1) * COLUMNS + x] = fill_char;
        for (int y = 0; y < LINES - 1; y++)
            row_color[y] = row_color[y + 1];
        row_color[LINES - 1] = fill_color;
    endtask

    task automatic next_line(output logic scrolled);
        cur_col  = 0;
        scrolled = 1'b0;
        if (cur_line + 1 >= LINES) begin
            cur_line = LINES - 1;
            scroll_screen();
            scrolled = 1'b1;
        end else begin
            cur_line++;
        end
    endtask

    task automatic run_console_cmd(input t_cmd cmd, output t_res res);
        int unsigned col;
        int unsigned lin;
        logic        scrolled;
        col       = clamp_to(cmd.column, COLUMNS);
        lin       = clamp_to(cmd.line, LINES);
        scrolled  = 1'b0;
        res       = '0;
        case (cmd.mode)
            MODE_WRITE: begin
                screen[cur_line * COLUMNS + cur_col] = cmd.char_code;
                cur_col++;
                if (cur_col >= COLUMNS)
                    next_line(scrolled);
            end
            MODE_NEWLINE: next_line(scrolled);
            MODE_CLEAR: begin
                for (int i = 0; i < LINES * COLUMNS; i++)
                    screen[i] = fill_char;
                for (int y = 0; y < LINES; y++)
                    row_color[y] = fill_color;
                cur_col  = 0;
                cur_line = 0;
            end
            MODE_SETCUR: begin
                cur_col  = col;
                cur_line = lin;
            end
            MODE_PUT:   screen[lin * COLUMNS + col] = cmd.char_code;
            MODE_COLOR: row_color[lin] = cmd.line_color;
            MODE_READ:  res.read_char = screen[lin * COLUMNS + col];
            default: ;
        endcase
        res.cursor_column = 6'(cur_col);
        res.cursor_line   = 5'(cur_line);
        res.did_scroll    = scrolled;
    endtask

    task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
        if (fail_count < 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_cmd cmd;
        t_res want;
        if (!i_rst_n) begin
            cur_col    = 0;
            cur_line   = 0;
            fill_char  = FILL_CHAR_RST;
            fill_color = FILL_COLOR_RST;
            cursor_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILL_CHAR:  fill_char  = i_cfg_data;
                    CFG_FILL_COLOR: fill_color = i_cfg_data;
                    default: ;
                endcase
            end
            // compare before predicting: a result on the ports predates this edge's item
            if (i_pop && !i_empty) begin
                if (cursor_reports.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result with no command outstanding", $realtime);
                    fail_count++;
                end else begin
                    want = cursor_reports.pop_front();
                    if (i_read_char !== want.read_char)
                        flag_mismatch("read_char", want.read_char, i_read_char);
                    if (i_cursor_column !== want.cursor_column)
                        flag_mismatch("cursor_column", want.cursor_column, i_cursor_column);
                    if (i_cursor_line !== want.cursor_line)
                        flag_mismatch("cursor_line", want.cursor_line, i_cursor_line);
                    if (i_did_scroll !== want.did_scroll)
                        flag_mismatch("did_scroll", want.did_scroll, i_did_scroll);
                end
            end
            if (i_push && !i_full) begin
                cmd.mode       = i_mode;
                cmd.char_code  = i_char_code;
                cmd.column     = i_column;
                cmd.line       = i_line;
                cmd.line_color = i_line_color;
                run_console_cmd(cmd, want);
                cursor_reports.push_back(want);
            end
        end
        o_pending    <= cursor_reports.size();
        o_fail_count <= fail_count;
    end

endmodule

/* tb/text_console_cursor_scroll_top_tb.sv */
module text_console_cursor_scroll_top_tb;
    import tcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         COLUMNS     = 64;
    localparam int         LINES       = 32;
    // the block ignores this code; it only reports the cursor
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int         PHASE_ITEMS = 450;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [2:0]           i_mode;
    logic [7:0]           i_char_code;
    logic [5:0]           i_column;
    logic [4:0]           i_line;
    logic [7:0]           i_line_color;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [7:0]           o_read_char;
    logic [5:0]           o_cursor_column;
    logic [4:0]           o_cursor_line;
    logic                 o_did_scroll;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]           i_cfg_data;

    int fail_count;
    int pending;
    int sent_count    = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int run_phase     = 0;
    int phase3_start  = 0;
    logic rx_hold     = 1'b0;

    always #10 i_clk = ~i_clk;

    text_console_cursor_scroll_top #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_column        (i_column),
        .i_line          (i_line),
        .i_line_color    (i_line_color),
        .empty           (empty),
        .pop             (pop),
        .o_read_char     (o_read_char),
        .o_cursor_column (o_cursor_column),
        .o_cursor_line   (o_cursor_line),
        .o_did_scroll    (o_did_scroll),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    text_console_cursor_scroll_checker #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_column        (i_column),
        .i_line          (i_line),
        .i_line_color    (i_line_color),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_read_char     (o_read_char),
        .i_cursor_column (o_cursor_column),
        .i_cursor_line   (o_cursor_line),
        .i_did_scroll    (o_did_scroll),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver: pop at random, hold off completely while rx_hold is up.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Back pressure: once the last phase is under way, stop popping for a long
    // stretch while the sender keeps offering items, so the block fills and
    // drops full on the sender.
    initial begin
        wait (run_phase == 3 && sent_count >= phase3_start + 40);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Offer one item, idling first at the sender's rate. Keep push high on
    // return so back-to-back items never lower and raise it in one step.
    task automatic send_cmd(input logic [2:0] mode, input logic [7:0] ch,
                            input logic [5:0] col, input logic [4:0] lin,
                            input logic [7:0] color);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_mode       <= mode;
        i_char_code  <= ch;
        i_column     <= col;
        i_line       <= lin;
        i_line_color <= color;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sent_count++;
    endtask

    // Random command, weighted toward writes and reads, with the cursor and
    // coordinates pushed toward the right and bottom edges so wraps and
    // scrolls happen often.
    task automatic send_random_cmd();
        int unsigned pick;
        logic [2:0]  mode;
        logic [5:0]  col;
        logic [4:0]  lin;
        pick = $urandom_range(99);
        if (pick < 38)      mode = MODE_WRITE;
        else if (pick < 46) mode = MODE_NEWLINE;
        else if (pick < 48) mode = MODE_CLEAR;
        else if (pick < 58) mode = MODE_SETCUR;
        else if (pick < 70) mode = MODE_PUT;
        else if (pick < 78) mode = MODE_COLOR;
        else if (pick < 97) mode = MODE_READ;
        else                mode = MODE_UNUSED;
        col = $urandom_range(1) ? 6'($urandom_range(63)) : 6'($urandom_range(63, 60));
        lin = $urandom_range(1) ? 5'($urandom_range(31)) : 5'($urandom_range(31, 29));
        send_cmd(mode, 8'($urandom_range(255)), col, lin, 8'($urandom_range(255)));
    endtask

    // Write both fill registers; the block must be idle.
    task automatic set_fill(input logic [7:0] ch, input logic [7:0] color);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FILL_CHAR;
        i_cfg_data <= ch;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FILL_COLOR;
        i_cfg_data <= color;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Drain every outstanding result, then wait out the length of a full clear sweep;
    // a refill pushes its result with its last cell, so none runs behind the last result.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (LINES * COLUMNS + 16) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_mode       <= MODE_WRITE;
        i_char_code  <= '0;
        i_column     <= '0;
        i_line       <= '0;
        i_line_color <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_FILL_CHAR;
        i_cfg_data   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase 1: sender idles now and then, receiver about half the time.
        run_phase   = 1;
        tx_idle_pct = 11;
        rx_idle_pct = 51;
        set_fill(8'h00, 8'hFF);

        // Directed part. The store is undefined after reset, so read only
        // cells put beforehand until the clear has filled every cell.
        send_cmd(MODE_PUT, 8'hAB, 6'd63, 5'd31, 8'h00);
        send_cmd(MODE_READ, 8'h00, 6'd63, 5'd31, 8'h00);
        send_cmd(MODE_PUT, 8'h00, 6'd0, 5'd0, 8'h00);
        send_cmd(MODE_READ, 8'hFF, 6'd0, 5'd0, 8'hFF);
        send_cmd(MODE_UNUSED, 8'hFF, 6'd63, 5'd31, 8'hFF);
        send_cmd(MODE_CLEAR, 8'h00, 6'd0, 5'd0, 8'h00);
        send_cmd(MODE_READ, 8'h00, 6'd17, 5'd9, 8'h00);
        send_cmd(MODE_COLOR, 8'h00, 6'd0, 5'd31, 8'hFF);
        send_cmd(MODE_COLOR, 8'h00, 6'd0, 5'd0, 8'h00);
        send_cmd(MODE_WRITE, 8'hFF, 6'd0, 5'd0, 8'h00);
        // write into the last column: wrap to the next line
        send_cmd(MODE_SETCUR, 8'h00, 6'd63, 5'd5, 8'h00);
        send_cmd(MODE_WRITE, 8'h41, 6'd0, 5'd0, 8'h00);
        // wrap off the last line: scroll and stay on the bottom line
        send_cmd(MODE_SETCUR, 8'h00, 6'd62, 5'd31, 8'h00);
        send_cmd(MODE_WRITE, 8'h42, 6'd0, 5'd0, 8'h00);
        send_cmd(MODE_WRITE, 8'h43, 6'd0, 5'd0, 8'h00);
        send_cmd(MODE_READ, 8'h00, 6'd62, 5'd30, 8'h00);
        send_cmd(MODE_READ, 8'h00, 6'd63, 5'd30, 8'h00);
        send_cmd(MODE_READ, 8'h00, 6'd0, 5'd31, 8'h00);
        // new line on the last line scrolls again
        send_cmd(MODE_NEWLINE, 8'h00, 6'd0, 5'd0, 8'h00);
        send_cmd(MODE_SETCUR, 8'h00, 6'd0, 5'd0, 8'h00);
        send_cmd(MODE_NEWLINE, 8'h00, 6'd0, 5'd0, 8'h00);
        send_cmd(MODE_READ, 8'h00, 6'd0, 5'd0, 8'h00);

        wait_idle();
        set_fill(8'hFF, 8'h00);
        repeat (PHASE_ITEMS) send_random_cmd();

        // Phase 2: swap the idle rates, random fill values.
        wait_idle();
        run_phase   = 2;
        tx_idle_pct = 51;
        rx_idle_pct = 11;
        set_fill(8'($urandom_range(255)), 8'($urandom_range(255)));
        repeat (PHASE_ITEMS) send_random_cmd();

        // Phase 3: full rate on both sides, plus the long receiver hold-off.
        wait_idle();
        set_fill(8'd32, 8'h80);
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        phase3_start = sent_count;
        run_phase    = 3;
        repeat (PHASE_ITEMS) send_random_cmd();

        // Drain, then wait out any stray results before the verdict.
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: several times the run where every item is a full clear sweep.
    initial begin
        #300000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
